FILE: design/ntss_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and register map of the substitution sampler
package ntss_pkg;

	// fixed point
	localparam int FRAC_BITS = 24;
	localparam logic [39:0] LN2_Q40 = 40'hB17217F7D2;
	localparam int TAYLOR_TERMS = 13;
	localparam logic [33:0] K_UNIT = 34'd1 << FRAC_BITS;
	localparam logic [24:0] ONE_Q = 25'd1 << FRAC_BITS;

	// pipeline depths
	localparam int EXP_LAT = 9 + 2 * (TAYLOR_TERMS - 1);
	localparam int PICK_LAT = 4;
	localparam int PIPE_LAT = EXP_LAT + PICK_LAT;

	// class-share divider
	localparam int DIV_STEPS = 40;

	// register map
	localparam logic [2:0] REG_FREQ_A = 3'd0;
	localparam logic [2:0] REG_FREQ_C = 3'd1;
	localparam logic [2:0] REG_FREQ_G = 3'd2;
	localparam logic [2:0] REG_FREQ_T = 3'd3;
	localparam logic [2:0] REG_KR = 3'd4;
	localparam logic [2:0] REG_KY = 3'd5;

	localparam logic [15:0] FREQ_RST = 16'd16384;
	localparam logic [15:0] RATIO_RST = 16'd256;

	// base codes
	localparam logic [1:0] BASE_A = 2'd0;
	localparam logic [1:0] BASE_C = 2'd1;
	localparam logic [1:0] BASE_G = 2'd2;
	localparam logic [1:0] BASE_T = 2'd3;

	typedef struct packed {
		logic [1:0] ancestor_base;
		logic [23:0] branch_length;
		logic [23:0] uniform_draw;
	} in_t;

	typedef struct packed {
		logic [1:0] descendant_base;
		logic config_fault;
	} out_t;

	// config-derived values handed from the coefficient unit
	typedef struct packed {
		logic [3:0][15:0] freq;
		logic [3:0][24:0] quot;
		logic [33:0] karg_r;
		logic [33:0] karg_y;
		logic fault;
	} coef_t;

endpackage

FILE: design/nucleotide_substitution_sampler.sv
`timescale 1ns / 1ps
// top level of the tn93 nucleotide substitution sampler
// Takes one request per cycle while in_ready is high and returns one result
// per request, in order (three 33-stage exponential pipelines run side by
// side, then four stages form the probabilities and pick the base).
// A stall on the output freezes the whole pipeline and drops in_ready. After
// reset and after every write to a known register, the per-base class shares
// are recomputed by a one-bit-per-cycle divider, and in_ready stays low
// while that runs. Configuration writes are always taken.
module nucleotide_substitution_sampler import ntss_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output out_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [15:0] cfg_data
);

	coef_t coef;
	logic busy;
	logic en;
	logic acc;
	logic [PIPE_LAT-1:0] vld_s;
	logic [1:0] base_s [0:EXP_LAT-1];
	logic [23:0] draw_s [0:EXP_LAT-1];
	logic [24:0] e;
	logic [24:0] er;
	logic [24:0] ey;

	// global advance: only a held result stops the pipe
	assign en = !vld_s[PIPE_LAT-1] || out_ready;
	assign in_ready = en && !busy;
	assign acc = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	ntss_coef u_coef (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.coef(coef),
		.busy(busy)
	);

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[PIPE_LAT-2:0], acc};
		end
	end

	// ancestor and draw wait alongside the exponentials
	always_ff @(posedge clk) begin
		if (en) begin
			base_s[0] <= in_data.ancestor_base;
			draw_s[0] <= in_data.uniform_draw;
			for (int i = 1; i < EXP_LAT; i++) begin
				base_s[i] <= base_s[i-1];
				draw_s[i] <= draw_s[i-1];
			end
		end
	end

	ntss_exp u_exp_e (
		.clk(clk),
		.en(en),
		.ut(in_data.branch_length),
		.karg(K_UNIT),
		.y(e)
	);

	ntss_exp u_exp_r (
		.clk(clk),
		.en(en),
		.ut(in_data.branch_length),
		.karg(coef.karg_r),
		.y(er)
	);

	ntss_exp u_exp_y (
		.clk(clk),
		.en(en),
		.ut(in_data.branch_length),
		.karg(coef.karg_y),
		.y(ey)
	);

	ntss_pick u_pick (
		.clk(clk),
		.en(en),
		.coef(coef),
		.base(base_s[EXP_LAT-1]),
		.draw(draw_s[EXP_LAT-1]),
		.e(e),
		.er(er),
		.ey(ey),
		.res(out_data)
	);

	assign out_valid = vld_s[PIPE_LAT-1];

endmodule

FILE: design/ntss_coef.sv
`timescale 1ns / 1ps
// configuration registers and the class-share divider
module ntss_coef import ntss_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	input logic [2:0] cfg_index,
	input logic [15:0] cfg_data,
	output coef_t coef,
	output logic busy
);

	logic [3:0][15:0] freq_q;
	logic [15:0] kr_q;
	logic [15:0] ky_q;
	logic start_q;
	logic run_q;
	logic [5:0] cnt_q;
	logic [3:0][15:0] dvd_q;
	logic [3:0][16:0] rem_q;
	logic [3:0][24:0] quo_q;
	logic [33:0] karg_r_q;
	logic [33:0] karg_y_q;
	logic fault_q;
	logic [16:0] pr;
	logic [16:0] py;
	logic wr_hit;
	logic [3:0][16:0] dsr;
	logic [3:0][17:0] trial;
	logic [3:0] ge;

	assign wr_hit = cfg_valid && (cfg_index <= REG_KY);
	assign pr = {1'b0, freq_q[0]} + {1'b0, freq_q[2]};
	assign py = {1'b0, freq_q[1]} + {1'b0, freq_q[3]};

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= {4{FREQ_RST}};
			kr_q <= RATIO_RST;
			ky_q <= RATIO_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FREQ_A: freq_q[0] <= cfg_data;
				REG_FREQ_C: freq_q[1] <= cfg_data;
				REG_FREQ_G: freq_q[2] <= cfg_data;
				REG_FREQ_T: freq_q[3] <= cfg_data;
				REG_KR: kr_q <= cfg_data;
				REG_KY: ky_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// divisor is the class sum of each base
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			dsr[i] = i[0] ? py : pr;
			trial[i] = {rem_q[i], dvd_q[i][15]};
			ge[i] = trial[i] >= {1'b0, dsr[i]};
		end
	end

	// divider control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b1;
			run_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			start_q <= wr_hit;
			if (start_q) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(DIV_STEPS - 1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// restoring division, one quotient bit per cycle for all four bases
	always_ff @(posedge clk) begin
		if (start_q) begin
			dvd_q <= freq_q;
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			for (int i = 0; i < 4; i++) begin
				dvd_q[i] <= dvd_q[i] << 1;
				rem_q[i] <= ge[i] ? 17'(trial[i] - {1'b0, dsr[i]}) : trial[i][16:0];
				quo_q[i] <= {quo_q[i][23:0], ge[i]};
			end
		end
	end

	// exponent rate factors and the zero class flag
	always_ff @(posedge clk) begin
		karg_r_q <= (34'(pr) * 34'(kr_q)) + (34'(py) << 8);
		karg_y_q <= (34'(py) * 34'(ky_q)) + (34'(pr) << 8);
		fault_q <= (pr == 17'd0) || (py == 17'd0);
	end

	assign busy = start_q || run_q;
	assign coef.freq = freq_q;
	assign coef.quot = quo_q;
	assign coef.karg_r = karg_r_q;
	assign coef.karg_y = karg_y_q;
	assign coef.fault = fault_q;

endmodule

FILE: design/ntss_exp.sv
`timescale 1ns / 1ps
// pipelined exp(-ut*k): argument product, ln2 range reduction, taylor series
module ntss_exp import ntss_pkg::*; (
	input logic clk,
	input logic en,
	input logic [23:0] ut,
	input logic [33:0] karg,
	output logic [24:0] y
);

	localparam int NT = TAYLOR_TERMS - 1;
	localparam logic [57:0] LIM = 58'(LN2_Q40) * 58'd33;

	logic [40:0] plo_s1;
	logic [40:0] phi_s1;
	logic [57:0] x_s2;

	// range reduction stages
	logic [44:0] rem_in [0:5];
	logic [5:0] n_in [0:5];
	logic big_in [0:5];
	logic [44:0] rem_ns [1:6];
	logic [5:0] n_ns [1:6];
	logic big_ns [1:6];

	// taylor stages
	logic [31:0] term_in [0:NT-1];
	logic [33:0] pos_in [0:NT-1];
	logic [33:0] neg_in [0:NT-1];
	logic [31:0] r_in [0:NT-1];
	logic [5:0] tn_in [0:NT-1];
	logic tbig_in [0:NT-1];
	logic [31:0] prd_ta [0:NT-1];
	logic [33:0] pos_ta [0:NT-1];
	logic [33:0] neg_ta [0:NT-1];
	logic [31:0] r_ta [0:NT-1];
	logic [5:0] n_ta [0:NT-1];
	logic big_ta [0:NT-1];
	logic [31:0] term_tb [1:NT];
	logic [33:0] pos_tb [1:NT];
	logic [33:0] neg_tb [1:NT];
	logic [31:0] r_tb [1:NT];
	logic [5:0] n_tb [1:NT];
	logic big_tb [1:NT];

	logic [33:0] diff;
	logic [33:0] shd;
	logic [24:0] y_q;

	// argument product in two halves
	always_ff @(posedge clk) begin
		if (en) begin
			plo_s1 <= 41'(ut) * 41'(karg[16:0]);
			phi_s1 <= 41'(ut) * 41'(karg[33:17]);
			x_s2 <= 58'(plo_s1) + (58'(phi_s1) << 17);
		end
	end

	// stage inputs of the reduction chain
	always_comb begin
		rem_in[0] = x_s2[44:0];
		n_in[0] = '0;
		big_in[0] = x_s2 >= LIM;
		for (int j = 1; j < 6; j++) begin
			rem_in[j] = rem_ns[j];
			n_in[j] = n_ns[j];
			big_in[j] = big_ns[j];
		end
	end

	// one quotient bit of x / ln2 per stage
	for (genvar j = 0; j < 6; j++) begin : g_red
		localparam logic [44:0] CL = 45'(LN2_Q40) << (5 - j);
		logic ge;
		assign ge = rem_in[j] >= CL;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_ns[j+1] <= ge ? rem_in[j] - CL : rem_in[j];
				n_ns[j+1] <= n_in[j] | (6'(ge) << (5 - j));
				big_ns[j+1] <= big_in[j];
			end
		end
	end

	// first term of the series is r itself
	always_comb begin
		term_in[0] = rem_ns[6][39:8];
		pos_in[0] = 34'd1 << 32;
		neg_in[0] = 34'(rem_ns[6][39:8]);
		r_in[0] = rem_ns[6][39:8];
		tn_in[0] = n_ns[6];
		tbig_in[0] = big_ns[6];
		for (int g = 1; g < NT; g++) begin
			term_in[g] = term_tb[g];
			pos_in[g] = pos_tb[g];
			neg_in[g] = neg_tb[g];
			r_in[g] = r_tb[g];
			tn_in[g] = n_tb[g];
			tbig_in[g] = big_tb[g];
		end
	end

	// each term: multiply by r, then divide by k through a reciprocal
	for (genvar g = 0; g < NT; g++) begin : g_tay
		localparam int unsigned KD = g + 2;
		localparam int unsigned LS = $clog2(KD);
		localparam logic [32:0] MR = 33'(((65'd1 << (32 + LS)) + KD - 1) / KD);
		logic [31:0] q;
		assign q = 32'((65'(prd_ta[g]) * 65'(MR)) >> (32 + LS));
		always_ff @(posedge clk) begin
			if (en) begin
				prd_ta[g] <= 32'((64'(term_in[g]) * 64'(r_in[g])) >> 32);
				pos_ta[g] <= pos_in[g];
				neg_ta[g] <= neg_in[g];
				r_ta[g] <= r_in[g];
				n_ta[g] <= tn_in[g];
				big_ta[g] <= tbig_in[g];
				term_tb[g+1] <= q;
				pos_tb[g+1] <= (KD % 2 == 0) ? pos_ta[g] + 34'(q) : pos_ta[g];
				neg_tb[g+1] <= (KD % 2 == 1) ? neg_ta[g] + 34'(q) : neg_ta[g];
				r_tb[g+1] <= r_ta[g];
				n_tb[g+1] <= n_ta[g];
				big_tb[g+1] <= big_ta[g];
			end
		end
	end

	// combine, scale by 2^-n and drop to Q.24
	assign diff = (pos_tb[NT] > neg_tb[NT]) ? pos_tb[NT] - neg_tb[NT] : '0;
	assign shd = diff >> n_tb[NT];

	always_ff @(posedge clk) begin
		if (en) begin
			y_q <= big_tb[NT] ? '0 : shd[32:8];
		end
	end

	assign y = y_q;

endmodule

FILE: design/ntss_pick.sv
`timescale 1ns / 1ps
// tn93 probabilities from the three exponentials and the cumulative pick
module ntss_pick import ntss_pkg::*; (
	input logic clk,
	input logic en,
	input coef_t coef,
	input logic [1:0] base,
	input logic [23:0] draw,
	input logic [24:0] e,
	input logic [24:0] er,
	input logic [24:0] ey,
	output out_t res
);

	logic pur;
	logic [1:0] mate;
	logic [1:0] tv1;
	logic [16:0] pr;
	logic [16:0] py;
	logic [24:0] qf;
	logic [24:0] s;
	logic [24:0] m;
	logic [24:0] ec;

	logic [25:0] a1_s1;
	logic [25:0] a2_s1;
	logic [24:0] c_s1;
	logic [24:0] tv_s1;
	logic [24:0] e_s1;
	logic [15:0] fs_s1;
	logic [15:0] fm_s1;
	logic [1:0] base_s1;
	logic [23:0] draw_s1;

	logic [26:0] b1_s2;
	logic [26:0] b2_s2;
	logic [24:0] c_s2;
	logic [24:0] tv_s2;
	logic [15:0] fs_s2;
	logic [15:0] fm_s2;
	logic [1:0] base_s2;
	logic [23:0] draw_s2;

	logic [30:0] same;
	logic [30:0] tsup;
	logic [30:0] ts;
	logic [30:0] cum1_s3;
	logic [30:0] cum2_s3;
	logic [30:0] cum3_s3;
	logic [1:0] base_s3;
	logic [23:0] draw_s3;

	logic pur3;
	logic [1:0] pick;
	out_t res_s4;

	// per-base selections
	assign pur = !base[0];
	assign mate = base ^ BASE_G;
	assign tv1 = pur ? BASE_C : BASE_A;
	assign pr = {1'b0, coef.freq[0]} + {1'b0, coef.freq[2]};
	assign py = {1'b0, coef.freq[1]} + {1'b0, coef.freq[3]};
	assign qf = (pur ? 25'(py) : 25'(pr)) << 8;
	assign s = coef.quot[base];
	assign m = coef.quot[mate];
	assign ec = pur ? er : ey;

	// first products
	always_ff @(posedge clk) begin
		if (en) begin
			a1_s1 <= 26'((50'(s) * 50'(qf)) >> FRAC_BITS);
			a2_s1 <= 26'((50'(m) * 50'(qf)) >> FRAC_BITS);
			c_s1 <= 25'((50'(m) * 50'(ec)) >> FRAC_BITS);
			tv_s1 <= 25'((49'({coef.freq[tv1], 8'd0}) * 49'(ONE_Q - e)) >> FRAC_BITS);
			e_s1 <= e;
			fs_s1 <= coef.freq[base];
			fm_s1 <= coef.freq[mate];
			base_s1 <= base;
			draw_s1 <= draw;
		end
	end

	// scale by exp(-ut)
	always_ff @(posedge clk) begin
		if (en) begin
			b1_s2 <= 27'((51'(a1_s1) * 51'(e_s1)) >> FRAC_BITS);
			b2_s2 <= 27'((51'(a2_s1) * 51'(e_s1)) >> FRAC_BITS);
			c_s2 <= c_s1;
			tv_s2 <= tv_s1;
			fs_s2 <= fs_s1;
			fm_s2 <= fm_s1;
			base_s2 <= base_s1;
			draw_s2 <= draw_s1;
		end
	end

	// cumulative sums, transition term clamps at zero
	assign same = (31'(fs_s2) << 8) + 31'(b1_s2) + 31'(c_s2);
	assign tsup = (31'(fm_s2) << 8) + 31'(b2_s2);
	assign ts = (tsup > 31'(c_s2)) ? tsup - 31'(c_s2) : '0;

	always_ff @(posedge clk) begin
		if (en) begin
			cum1_s3 <= same;
			cum2_s3 <= same + ts;
			cum3_s3 <= same + ts + 31'(tv_s2);
			base_s3 <= base_s2;
			draw_s3 <= draw_s2;
		end
	end

	// compare the draw against each cumulative bound
	assign pur3 = !base_s3[0];
	always_comb begin
		if (31'(draw_s3) < cum1_s3) begin
			pick = base_s3;
		end else if (31'(draw_s3) < cum2_s3) begin
			pick = base_s3 ^ BASE_G;
		end else if (31'(draw_s3) < cum3_s3) begin
			pick = pur3 ? BASE_C : BASE_A;
		end else begin
			pick = pur3 ? BASE_T : BASE_G;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s4.descendant_base <= coef.fault ? base_s3 : pick;
			res_s4.config_fault <= coef.fault;
		end
	end

	assign res = res_s4;

endmodule

FILE: design/ntss_check.sv
`timescale 1ns / 1ps
// port-level checks of the sampler and their bind
module ntss_check import ntss_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [2:0] cfg_index
);

	// a held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// a stalled output blocks new requests
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("request taken during output stall");

	// a register write starts a recompute
	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && (cfg_index <= REG_KY) |=> !in_ready)
		else $error("request taken right after a register write");

	// coefficients are not ready as reset lifts
	a_reset_busy: assert property (@(posedge clk)
		$rose(arst_n) |-> !in_ready)
		else $error("request taken before coefficients exist");

endmodule

bind nucleotide_substitution_sampler ntss_check u_check (.*);

FILE: verif/nucleotide_substitution_sampler_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the tn93 substitution sampler: directed cases, then random phases
module nucleotide_substitution_sampler_tb;
	import ntss_pkg::*;

	localparam int LIMIT_CYCLES = 600000;
	localparam int DRAIN_CYCLES = PIPE_LAT + DIV_STEPS + 20;
	localparam int HOLD_CYCLES = 300;
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	typedef struct {
		in_t req;
		bit typed;
		out_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// predictor copy of the register file
	logic [63:0] base_freq [4];
	logic [63:0] ratio_kr, ratio_ky;

	out_t sample_q [$];
	bit cur_typed = 1'b0;
	out_t cur_want = '0;
	int errors = 0;
	int cycles = 0;
	bit hold_req = 1'b0;
	int burst_left = 0;
	row_t dir_rows [$];

	nucleotide_substitution_sampler u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// exp(-x), x in q.40, result in q.FRAC_BITS
	function automatic logic [63:0] exp_decay(logic [63:0] x);
		logic [63:0] n, r, term, pos, neg, y;
		n = x / LN2_Q40;
		if (n > 64'd32) begin
			return 64'd0;
		end
		r = (x - n * LN2_Q40) >> 8;
		term = 64'd1 << 32;
		pos = term;
		neg = 64'd0;
		for (int k = 1; k <= TAYLOR_TERMS; k++) begin
			term = ((term * r) >> 32) / k;
			if (k % 2 == 1) begin
				neg += term;
			end else begin
				pos += term;
			end
		end
		y = (pos > neg) ? pos - neg : 64'd0;
		y = y >> n;
		return y >> (32 - FRAC_BITS);
	endfunction

	function automatic logic [63:0] mul_q(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[63 + FRAC_BITS:FRAC_BITS];
	endfunction

	// descendant base drawn from the tn93 transition row of the ancestor
	function automatic out_t sample_base(in_t req);
		out_t o;
		logic [63:0] pr, py, ut, x, e, er, ey, own, oth, ec, s, m, qf;
		logic [63:0] same, tsup, tsdn, ts, tv, xs, cum;
		logic [1:0] b, mate, tv1, tv2;
		bit pur;
		b = req.ancestor_base;
		ut = 64'(req.branch_length);
		x = 64'(req.uniform_draw);
		pr = base_freq[BASE_A] + base_freq[BASE_G];
		py = base_freq[BASE_C] + base_freq[BASE_T];
		o.config_fault = 1'b0;
		if (pr == 0 || py == 0) begin
			o.descendant_base = b;
			o.config_fault = 1'b1;
			return o;
		end
		e = exp_decay(ut << 24);
		er = exp_decay(ut * (pr * ratio_kr + (py << 8)));
		ey = exp_decay(ut * (py * ratio_ky + (pr << 8)));
		pur = (b == BASE_A) || (b == BASE_G);
		own = pur ? pr : py;
		oth = pur ? py : pr;
		ec = pur ? er : ey;
		mate = b ^ BASE_G;
		tv1 = pur ? BASE_C : BASE_A;
		tv2 = pur ? BASE_T : BASE_G;
		s = (base_freq[b] << FRAC_BITS) / own;
		m = (base_freq[mate] << FRAC_BITS) / own;
		qf = oth << (FRAC_BITS - 16);
		same = (base_freq[b] << (FRAC_BITS - 16)) + mul_q(mul_q(s, qf), e) + mul_q(m, ec);
		tsup = (base_freq[mate] << (FRAC_BITS - 16)) + mul_q(mul_q(m, qf), e);
		tsdn = mul_q(m, ec);
		ts = (tsup > tsdn) ? tsup - tsdn : 64'd0;
		tv = mul_q(base_freq[tv1] << (FRAC_BITS - 16), 64'(ONE_Q) - e);
		xs = x << FRAC_BITS;
		cum = same;
		if (xs < (cum << 24)) begin
			o.descendant_base = b;
		end else begin
			cum += ts;
			if (xs < (cum << 24)) begin
				o.descendant_base = mate;
			end else begin
				cum += tv;
				o.descendant_base = (xs < (cum << 24)) ? tv1 : tv2;
			end
		end
		return o;
	endfunction

	task automatic report(string what, out_t got, out_t want);
		errors++;
		$display("MISMATCH %s: got base %0d fault %0d, want base %0d fault %0d",
			what, got.descendant_base, got.config_fault,
			want.descendant_base, want.config_fault);
	endtask

	// run time limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("nucleotide_substitution_sampler verification failed");
			$finish;
		end
	end

	// record expectation of every accepted request
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			sample_q.push_back(cur_typed ? cur_want : sample_base(in_data));
		end
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (sample_q.size() == 0) begin
				report("unexpected result", out_data, '0);
			end else begin
				want = sample_q.pop_front();
				if (out_data.descendant_base !== want.descendant_base)
					report("descendant_base", out_data, want);
				if (out_data.config_fault !== want.config_fault)
					report("config_fault", out_data, want);
			end
		end
	end

	// receiver stall pattern, with an occasional long hold-off
	always begin
		int pct;
		int left;
		pct = 100;
		left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			if (left == 0) begin
				left = $urandom_range(10, 80);
				case ($urandom_range(0, 3))
					0: pct = 100;
					1: pct = 50;
					2: pct = 15;
					default: pct = 85;
				endcase
			end
			left--;
			out_ready <= ($urandom_range(0, 99) < pct);
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [15:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_FREQ_A: base_freq[BASE_A] = 64'(value);
			REG_FREQ_C: base_freq[BASE_C] = 64'(value);
			REG_FREQ_G: base_freq[BASE_G] = 64'(value);
			REG_FREQ_T: base_freq[BASE_T] = 64'(value);
			REG_KR: ratio_kr = 64'(value);
			REG_KY: ratio_ky = 64'(value);
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// offer one request, in bursts with random gaps in between
	task automatic send_req(in_t req, bit typed, out_t want);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 2) != 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat ($urandom_range(0, 6)) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= req;
		cur_typed = typed;
		cur_want = want;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sample_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic in_t rand_req();
		in_t r;
		r.ancestor_base = 2'($urandom_range(0, 3));
		case ($urandom_range(0, 3))
			0: r.branch_length = 24'($urandom_range(0, 255));
			1: r.branch_length = 24'($urandom_range(0, 65535));
			2: r.branch_length = 24'($urandom_range(0, 400000));
			default: r.branch_length = 24'($urandom);
		endcase
		r.uniform_draw = 24'($urandom);
		return r;
	endfunction

	task automatic random_phase(int count, bit long_hold);
		for (int i = 0; i < count; i++) begin
			if (long_hold && i == 5) hold_req = 1'b1;
			send_req(rand_req(), 1'b0, '0);
		end
		drain();
	endtask

	function automatic row_t mk_row(logic [1:0] b, logic [23:0] ut, logic [23:0] x, bit typed);
		row_t r;
		r.req.ancestor_base = b;
		r.req.branch_length = ut;
		r.req.uniform_draw = x;
		r.typed = typed;
		r.want.descendant_base = b;
		r.want.config_fault = 1'b0;
		return r;
	endfunction

	initial begin
		base_freq[BASE_A] = 64'(FREQ_RST);
		base_freq[BASE_C] = 64'(FREQ_RST);
		base_freq[BASE_G] = 64'(FREQ_RST);
		base_freq[BASE_T] = 64'(FREQ_RST);
		ratio_kr = 64'(RATIO_RST);
		ratio_ky = 64'(RATIO_RST);
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// zero branch keeps the ancestor at reset frequencies
		for (int b = 0; b < 4; b++) begin
			dir_rows.push_back(mk_row(2'(b), 24'd0, 24'd0, 1'b1));
			dir_rows.push_back(mk_row(2'(b), 24'd0, 24'hFFFFFF, 1'b1));
		end
		// longest branch, short branch, draw extremes
		for (int b = 0; b < 4; b++) begin
			dir_rows.push_back(mk_row(2'(b), 24'hFFFFFF, 24'h000000, 1'b0));
			dir_rows.push_back(mk_row(2'(b), 24'hFFFFFF, 24'hFFFFFF, 1'b0));
			dir_rows.push_back(mk_row(2'(b), 24'd40000, 24'h7FFFFF, 1'b0));
			dir_rows.push_back(mk_row(2'(b), 24'd1, 24'hFFFFFE, 1'b0));
		end
		foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
		drain();

		// empty purine class raises the fault and echoes the ancestor
		write_reg(REG_FREQ_A, 16'd0);
		write_reg(REG_FREQ_G, 16'd0);
		for (int b = 0; b < 4; b++) begin
			row_t r;
			r = mk_row(2'(b), 24'($urandom), 24'($urandom), 1'b1);
			r.want.config_fault = 1'b1;
			send_req(r.req, r.typed, r.want);
		end
		drain();

		// empty pyrimidine class, unused indexes ignored
		write_reg(REG_FREQ_A, 16'd30000);
		write_reg(REG_FREQ_G, 16'd20000);
		write_reg(REG_FREQ_C, 16'd0);
		write_reg(REG_FREQ_T, 16'd0);
		write_reg(REG_SPARE_LO, 16'hFFFF);
		write_reg(REG_SPARE_HI, 16'h0000);
		random_phase(20, 1'b0);

		// all registers at maximum, long receiver hold-off
		write_reg(REG_FREQ_A, 16'hFFFF);
		write_reg(REG_FREQ_C, 16'hFFFF);
		write_reg(REG_FREQ_G, 16'hFFFF);
		write_reg(REG_FREQ_T, 16'hFFFF);
		write_reg(REG_KR, 16'hFFFF);
		write_reg(REG_KY, 16'hFFFF);
		random_phase(100, 1'b1);

		// zero ratios, skewed frequencies not summing to one
		write_reg(REG_KR, 16'd0);
		write_reg(REG_KY, 16'd0);
		write_reg(REG_FREQ_A, 16'd1);
		write_reg(REG_FREQ_C, 16'd3000);
		write_reg(REG_FREQ_G, 16'd60000);
		write_reg(REG_FREQ_T, 16'd2);
		random_phase(90, 1'b0);

		// several random settings
		for (int p = 0; p < 3; p++) begin
			write_reg(REG_FREQ_A, 16'($urandom));
			write_reg(REG_FREQ_C, 16'($urandom));
			write_reg(REG_FREQ_G, 16'($urandom));
			write_reg(REG_FREQ_T, 16'($urandom));
			write_reg(REG_KR, 16'($urandom_range(0, 4096)));
			write_reg(REG_KY, 16'($urandom));
			random_phase(80, 1'b0);
		end

		// back to a balanced setting
		write_reg(REG_FREQ_A, FREQ_RST);
		write_reg(REG_FREQ_C, FREQ_RST);
		write_reg(REG_FREQ_G, FREQ_RST);
		write_reg(REG_FREQ_T, FREQ_RST);
		write_reg(REG_KR, 16'd1024);
		write_reg(REG_KY, 16'd512);
		random_phase(80, 1'b0);

		if (errors == 0) begin
			$display("nucleotide_substitution_sampler verification clean");
		end else begin
			$display("nucleotide_substitution_sampler verification failed");
		end
		$finish;
	end

endmodule

FILE: nucleotide_substitution_sampler.f
design/ntss_pkg.sv
design/ntss_coef.sv
design/ntss_exp.sv
design/ntss_pick.sv
design/nucleotide_substitution_sampler.sv
design/ntss_check.sv
verif/nucleotide_substitution_sampler_tb.sv
